// ===== hw/rtl/ulrb_pkg.sv =====
// Shared types and constants for the line-buffered receive ring buffer.
`default_nettype none
package ulrb_pkg;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic store_en;
      logic fetch_start;
      logic read_en;
      logic load_none;
      logic load_byte;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic out_free;
      logic last_byte;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/uart_line_ring_buffer.sv =====
// Top level of the line-buffered receive ring buffer.
`default_nettype none
// A store beat (req_mode 0) writes one received character into a DEPTH-entry
// ring; the buffer has no overflow guard, so unread data is overwritten and
// the waiting-line count saturates at 127. A fetch beat (req_mode 1) returns
// the oldest complete line, one rsp beat per character, with the last one
// marked, or a single no_line beat when nothing is waiting. A fetch is
// accepted in the idle state; each character then passes through the
// registered read of the line memory and the result register. Backpressure
// on rsp can stall the readout. Carriage return always ends a line; line feed
// ends one while the csr bit is set (reset value 1). Configure only while the
// block is idle.
module uart_line_ring_buffer #(
   parameter int DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_line,
   output logic            rsp_no_line,
   output logic [6:0]      rsp_lines_left,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_newline_terminates
);

   ulrb_pkg::cmd_type    cmd;
   ulrb_pkg::status_type status;
   ulrb_pkg::state_type  state;

   ulrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   ulrb_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .rx_byte                (req_rx_byte),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_newline_terminates (csr_newline_terminates),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_last_of_line       (rsp_last_of_line),
      .rsp_no_line            (rsp_no_line),
      .rsp_lines_left         (rsp_lines_left)
   );

   // A no_line beat always closes its run and reports an empty count.
   a_no_line_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_line |-> rsp_last_of_line && (rsp_lines_left == 7'd0))
      else $error("no_line beat with wrong shape");

   // An accepted fetch beat starts a readout on the next cycle.
   a_fetch_starts : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=> state == ulrb_pkg::ST_READ)
      else $error("fetch did not start a readout");

   // The result register is never overwritten while it still holds an untaken beat.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (cmd.load_byte || cmd.load_none) |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

endmodule
`default_nettype wire

// ===== hw/rtl/ulrb_ctrl.sv =====
// Controller state machine sequencing stores and line readouts.
`default_nettype none
module ulrb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_mode,
   output logic                      req_ready,
   input  wire ulrb_pkg::status_type status,
   output ulrb_pkg::cmd_type         cmd,
   output ulrb_pkg::state_type       state
);

   ulrb_pkg::state_type state_ff;
   ulrb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ulrb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ulrb_pkg::ST_IDLE: begin
            if (req_valid && req_mode) begin
               state_in = ulrb_pkg::ST_READ;
            end
         end
         ulrb_pkg::ST_READ: begin
            if (status.count_zero) begin
               if (status.out_free) begin
                  state_in = ulrb_pkg::ST_IDLE;
               end
            end else begin
               state_in = ulrb_pkg::ST_LOAD;
            end
         end
         ulrb_pkg::ST_LOAD: begin
            if (status.out_free) begin
               state_in = status.last_byte ? ulrb_pkg::ST_IDLE : ulrb_pkg::ST_READ;
            end
         end
         default: state_in = ulrb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      case (state_ff)
         ulrb_pkg::ST_IDLE: begin
            req_ready       = !reset;
            cmd.store_en    = req_valid && req_ready && !req_mode;
            cmd.fetch_start = req_valid && req_ready && req_mode;
         end
         ulrb_pkg::ST_READ: begin
            cmd.load_none = status.count_zero && status.out_free;
            cmd.read_en   = !status.count_zero;
         end
         ulrb_pkg::ST_LOAD: begin
            cmd.load_byte = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign state = state_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ulrb_dpath.sv =====
// Datapath: line memory, pointers, line count, configuration and result register.
`default_nettype none
module ulrb_dpath #(
   parameter int DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ulrb_pkg::cmd_type    cmd,
   output ulrb_pkg::status_type      status,
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_newline_terminates,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_line,
   output logic                      rsp_no_line,
   output logic [ulrb_pkg::COUNT_W-1:0] rsp_lines_left
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH) + 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ulrb_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic newline_ff, newline_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic last_ff, last_in;
   logic no_line_ff, no_line_in;
   logic [ulrb_pkg::COUNT_W-1:0] left_ff, left_in;

   logic rx_term;
   logic rd_term;
   logic out_free;

   assign rx_term = (rx_byte == ulrb_pkg::CHAR_CR) ||
                    (newline_ff && (rx_byte == ulrb_pkg::CHAR_LF));
   assign rd_term = (rd_data_ff == ulrb_pkg::CHAR_CR) ||
                    (newline_ff && (rd_data_ff == ulrb_pkg::CHAR_LF));
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.count_zero = (count_ff == '0);
   assign status.out_free   = out_free;
   assign status.last_byte  = rd_term || (byte_cnt_ff == CNT_FULL);

   always_ff @(posedge clock) begin
      if (cmd.store_en) begin
         mem[wr_ptr_ff] <= rx_byte;
      end
      if (cmd.read_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      byte_cnt_in = byte_cnt_ff;
      newline_in  = newline_ff;
      if (csr_valid) begin
         newline_in = csr_newline_terminates;
      end
      if (cmd.store_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (rx_term && (count_ff != ulrb_pkg::COUNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.fetch_start) begin
         byte_cnt_in = '0;
      end
      if (cmd.read_en) begin
         rd_ptr_in   = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         byte_cnt_in = byte_cnt_ff + 1'b1;
      end
      if (cmd.load_byte && status.last_byte) begin
         count_in = count_ff - 1'b1;
      end
   end

   // The result register is reloaded only when empty or being drained in the same cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      no_line_in   = no_line_ff;
      left_in      = left_ff;
      if (cmd.load_none) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = '0;
         last_in      = 1'b1;
         no_line_in   = 1'b1;
         left_in      = '0;
      end else if (cmd.load_byte) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = rd_data_ff;
         last_in      = status.last_byte;
         no_line_in   = 1'b0;
         left_in      = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         byte_cnt_ff  <= '0;
         newline_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         byte_cnt_ff  <= byte_cnt_in;
         newline_ff   <= newline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      no_line_ff  <= no_line_in;
      left_ff     <= left_in;
   end

   assign csr_ready        = !reset;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_last_of_line = last_ff;
   assign rsp_no_line      = no_line_ff;
   assign rsp_lines_left   = left_ff;

endmodule
`default_nettype wire
